// ===== hw/rtl/amd_pkg.sv =====
// shared types and constants for the accelerometer motion detector
// no dependencies; every rtl file refers to it by scoped names
package amd_pkg;

    // default parameter values handed down from the top level
    localparam int WINDOW_SAMPLES_DEF = 3;
    localparam int FRACTION_BITS_DEF  = 4;

    // fixed field widths
    localparam int ACCEL_W  = 16;
    localparam int SAMPLE_W = 14;
    localparam int MAG_W    = 18;
    localparam int LIMIT_W  = 4;
    localparam int STILL_W  = 5;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 18;
    localparam logic [CFG_IDX_W-1:0] CFG_MOTION_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STILL_LIMIT      = 2'd1;

    localparam logic [MAG_W-1:0]   THRESHOLD_RESET   = 18'd1640;
    localparam logic [LIMIT_W-1:0] STILL_LIMIT_RESET = 4'd3;
    localparam logic [STILL_W-1:0] STILL_MAX         = 5'd31;
    localparam logic [MAG_W-1:0]   MAG_MAX           = 18'h3FFFF;

    // baseline filter weights, in percent
    localparam int WEIGHT_W = 7;
    localparam logic [WEIGHT_W-1:0] WB_MOVE = 7'd70;
    localparam logic [WEIGHT_W-1:0] WM_MOVE = 7'd30;
    localparam logic [WEIGHT_W-1:0] WB_FAST = 7'd85;
    localparam logic [WEIGHT_W-1:0] WM_FAST = 7'd15;
    localparam logic [WEIGHT_W-1:0] WB_SLOW = 7'd95;
    localparam logic [WEIGHT_W-1:0] WM_SLOW = 7'd5;
    localparam int BASE_DIVISOR = 100;
    localparam int BASE_ROUND   = 50;

    typedef struct packed {
        logic signed [ACCEL_W-1:0] accel_x;
        logic signed [ACCEL_W-1:0] accel_y;
        logic signed [ACCEL_W-1:0] accel_z;
    } in_item_t;

    typedef struct packed {
        logic             moving;
        logic [MAG_W-1:0] window_magnitude;
        logic [MAG_W-1:0] new_baseline;
    } out_item_t;

    // per-sample control to the axis lanes
    typedef struct packed {
        logic add;
        logic close;
    } lane_ctl_t;

endpackage

// ===== hw/rtl/amd_axis_lane.sv =====
// one axis lane: window sum, bit-serial rounded average, bit-serial square
// depends on amd_pkg
module amd_axis_lane #(
    parameter int WINDOW_SAMPLES = amd_pkg::WINDOW_SAMPLES_DEF,
    parameter int FRACTION_BITS  = amd_pkg::FRACTION_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  amd_pkg::lane_ctl_t                  ctl,
    input  logic signed [amd_pkg::ACCEL_W-1:0]  accel,
    output logic                                busy,
    output logic [2*(amd_pkg::SAMPLE_W+FRACTION_BITS)-1:0] square
);

    localparam int SUM_W      = amd_pkg::SAMPLE_W + $clog2(WINDOW_SAMPLES);
    localparam int AVG_W      = amd_pkg::SAMPLE_W + FRACTION_BITS;
    localparam int DIVIDEND_W = SUM_W + FRACTION_BITS + 2;
    localparam int DIVISOR    = 2 * WINDOW_SAMPLES;
    localparam int REM_W      = $clog2(DIVISOR + 1);
    localparam int SQ_W       = 2 * AVG_W;
    localparam int CNT_W      = $clog2(AVG_W);

    localparam logic [1:0] L_IDLE = 2'd0;
    localparam logic [1:0] L_DIV  = 2'd1;
    localparam logic [1:0] L_MUL  = 2'd2;

    logic [1:0]              phase_reg, phase_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic [REM_W-1:0]        rem_reg, rem_next;
    logic [AVG_W-1:0]        sh_reg, sh_next;
    logic [AVG_W-1:0]        avg_reg, avg_next;
    logic [SQ_W-1:0]         prod_reg, prod_next;

    logic signed [amd_pkg::SAMPLE_W-1:0] sample;
    logic signed [SUM_W-1:0]             sum_total;
    logic [SUM_W-1:0]                    abs_val;
    logic [DIVIDEND_W-1:0]               dividend;
    logic [REM_W:0]                      trial;
    logic                                q_bit;
    logic                                last_step;

    // arithmetic shift right by two keeps the top 14 bits
    assign sample    = accel[amd_pkg::ACCEL_W-1:2];
    assign sum_total = sum_reg + SUM_W'(sample);
    assign abs_val   = sum_total[SUM_W-1] ? SUM_W'(-sum_total) : SUM_W'(sum_total);
    // round to nearest: (2*|sum|*2^F + W) / (2*W)
    assign dividend  = (DIVIDEND_W'(abs_val) << (FRACTION_BITS + 1))
                     + DIVIDEND_W'(WINDOW_SAMPLES);

    assign trial     = {rem_reg, sh_reg[AVG_W-1]};
    assign q_bit     = (trial >= (REM_W+1)'(DIVISOR));
    assign last_step = (cnt_reg == CNT_W'(AVG_W - 1));

    always_comb
    begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        sum_next   = sum_reg;
        rem_next   = rem_reg;
        sh_next    = sh_reg;
        avg_next   = avg_reg;
        prod_next  = prod_reg;
        case (phase_reg)
            L_IDLE:
            begin
                if (ctl.add)
                begin
                    sum_next = ctl.close ? '0 : sum_total;
                end
                if (ctl.close)
                begin
                    rem_next   = REM_W'(dividend >> AVG_W);
                    sh_next    = dividend[AVG_W-1:0];
                    prod_next  = '0;
                    cnt_next   = '0;
                    phase_next = L_DIV;
                end
            end
            L_DIV:
            begin
                // restoring division, one quotient bit per cycle
                rem_next = q_bit ? REM_W'(trial - (REM_W+1)'(DIVISOR)) : REM_W'(trial);
                sh_next  = {sh_reg[AVG_W-2:0], q_bit};
                cnt_next = cnt_reg + CNT_W'(1);
                if (last_step)
                begin
                    avg_next   = {sh_reg[AVG_W-2:0], q_bit};
                    cnt_next   = '0;
                    phase_next = L_MUL;
                end
            end
            L_MUL:
            begin
                // msb-first shift and add
                prod_next = (prod_reg << 1) + (sh_reg[AVG_W-1] ? SQ_W'(avg_reg) : '0);
                sh_next   = sh_reg << 1;
                cnt_next  = cnt_reg + CNT_W'(1);
                if (last_step)
                begin
                    phase_next = L_IDLE;
                end
            end
            default:
            begin
                phase_next = L_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= L_IDLE;
            cnt_reg   <= '0;
            sum_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            sum_reg   <= sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        sh_reg   <= sh_next;
        avg_reg  <= avg_next;
        prod_reg <= prod_next;
    end

    assign busy   = (phase_reg != L_IDLE);
    assign square = prod_reg;

endmodule

// ===== hw/rtl/amd_sqrt.sv =====
// bit-serial integer square root, rounded to nearest and saturated to 18 bits
// depends on amd_pkg
module amd_sqrt #(
    parameter int RAD_W = 2 * (amd_pkg::SAMPLE_W + amd_pkg::FRACTION_BITS_DEF) + 2
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [RAD_W-1:0]          radicand,
    output logic                      done,
    output logic [amd_pkg::MAG_W-1:0] magnitude
);

    localparam int ROOT_W = RAD_W / 2;
    localparam int REM_W  = ROOT_W + 2;
    localparam int CNT_W  = $clog2(ROOT_W);
    localparam int CMP_W  = (ROOT_W + 1 > amd_pkg::MAG_W) ? ROOT_W + 1 : amd_pkg::MAG_W;

    localparam logic [1:0] Q_IDLE  = 2'd0;
    localparam logic [1:0] Q_RUN   = 2'd1;
    localparam logic [1:0] Q_ROUND = 2'd2;

    logic [1:0]                phase_reg, phase_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic                      done_reg, done_next;
    logic [RAD_W-1:0]          rad_reg, rad_next;
    logic [ROOT_W-1:0]         root_reg, root_next;
    logic [REM_W-1:0]          rem_reg, rem_next;
    logic [amd_pkg::MAG_W-1:0] mag_reg, mag_next;

    logic [REM_W+1:0] rem_sh;
    logic [REM_W+1:0] trial;
    logic             ge;
    logic [CMP_W-1:0] rounded;

    assign rem_sh  = {rem_reg, rad_reg[RAD_W-1 -: 2]};
    assign trial   = (REM_W+2)'({root_reg, 2'b01});
    assign ge      = (rem_sh >= trial);
    assign rounded = CMP_W'(root_reg) + CMP_W'(rem_reg > REM_W'(root_reg));

    always_comb
    begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        rad_next   = rad_reg;
        root_next  = root_reg;
        rem_next   = rem_reg;
        mag_next   = mag_reg;
        case (phase_reg)
            Q_IDLE:
            begin
                if (start)
                begin
                    rad_next   = radicand;
                    root_next  = '0;
                    rem_next   = '0;
                    cnt_next   = '0;
                    phase_next = Q_RUN;
                end
            end
            Q_RUN:
            begin
                // two radicand bits in, one root bit out
                rem_next  = ge ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
                root_next = {root_reg[ROOT_W-2:0], ge};
                rad_next  = rad_reg << 2;
                cnt_next  = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(ROOT_W - 1))
                begin
                    phase_next = Q_ROUND;
                end
            end
            Q_ROUND:
            begin
                // remainder above the root means the true root is past the half
                mag_next   = (rounded > CMP_W'(amd_pkg::MAG_MAX)) ? amd_pkg::MAG_MAX
                                                                : amd_pkg::MAG_W'(rounded);
                done_next  = 1'b1;
                phase_next = Q_IDLE;
            end
            default:
            begin
                phase_next = Q_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= Q_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        root_reg <= root_next;
        rem_reg  <= rem_next;
        mag_reg  <= mag_next;
    end

    assign done      = done_reg;
    assign magnitude = mag_reg;

endmodule

// ===== hw/rtl/amd_baseline.sv =====
// motion decision, still counter and serial exponential baseline update
// depends on amd_pkg
module amd_baseline (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [amd_pkg::MAG_W-1:0]   magnitude,
    input  logic [amd_pkg::MAG_W-1:0]   motion_threshold,
    input  logic [amd_pkg::LIMIT_W-1:0] still_limit,
    output logic                        done,
    output amd_pkg::out_item_t          result
);

    localparam int MAG_W   = amd_pkg::MAG_W;
    localparam int WT_W    = amd_pkg::WEIGHT_W;
    localparam int NUM_W   = MAG_W + WT_W;
    localparam int REM_W   = $clog2(amd_pkg::BASE_DIVISOR);
    localparam int CNT_W   = $clog2(MAG_W);

    localparam logic [1:0] B_IDLE = 2'd0;
    localparam logic [1:0] B_MUL  = 2'd1;
    localparam logic [1:0] B_LOAD = 2'd2;
    localparam logic [1:0] B_DIV  = 2'd3;

    logic [1:0]                  phase_reg, phase_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic                        done_reg, done_next;
    logic                        valid_reg, valid_next;
    logic [amd_pkg::STILL_W-1:0] still_reg, still_next;
    logic [MAG_W-1:0]            base_reg, base_next;
    logic                        moving_reg, moving_next;
    logic [MAG_W-1:0]            mag_reg, mag_next;
    logic [WT_W-1:0]             wb_reg, wb_next;
    logic [WT_W-1:0]             wm_reg, wm_next;
    logic [NUM_W-1:0]            acc_reg, acc_next;
    logic [REM_W-1:0]            rem_reg, rem_next;
    logic [MAG_W-1:0]            quo_reg, quo_next;

    logic [MAG_W-1:0]            diff;
    logic                        is_moving;
    logic [amd_pkg::STILL_W-1:0] still_upd;
    logic                        fast;
    logic [NUM_W-1:0]            num;
    logic [REM_W:0]              trial;
    logic                        q_bit;

    assign diff      = (magnitude > base_reg) ? magnitude - base_reg : base_reg - magnitude;
    assign is_moving = (diff > motion_threshold);
    assign still_upd = is_moving ? '0
                     : ((still_reg < amd_pkg::STILL_MAX) ? still_reg + 1'b1 : still_reg);
    assign fast      = (still_upd > amd_pkg::STILL_W'(still_limit));
    assign num       = acc_reg + NUM_W'(amd_pkg::BASE_ROUND);
    assign trial     = {rem_reg, quo_reg[MAG_W-1]};
    assign q_bit     = (trial >= (REM_W+1)'(amd_pkg::BASE_DIVISOR));

    always_comb
    begin
        phase_next  = phase_reg;
        cnt_next    = cnt_reg;
        done_next   = 1'b0;
        valid_next  = valid_reg;
        still_next  = still_reg;
        base_next   = base_reg;
        moving_next = moving_reg;
        mag_next    = mag_reg;
        wb_next     = wb_reg;
        wm_next     = wm_reg;
        acc_next    = acc_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        case (phase_reg)
            B_IDLE:
            begin
                if (start)
                begin
                    mag_next = magnitude;
                    if (!valid_reg)
                    begin
                        // first window seeds the baseline
                        base_next   = magnitude;
                        valid_next  = 1'b1;
                        moving_next = 1'b0;
                        done_next   = 1'b1;
                    end
                    else
                    begin
                        moving_next = is_moving;
                        still_next  = still_upd;
                        if (is_moving)
                        begin
                            wb_next = amd_pkg::WB_MOVE;
                            wm_next = amd_pkg::WM_MOVE;
                        end
                        else if (fast)
                        begin
                            wb_next = amd_pkg::WB_FAST;
                            wm_next = amd_pkg::WM_FAST;
                        end
                        else
                        begin
                            wb_next = amd_pkg::WB_SLOW;
                            wm_next = amd_pkg::WM_SLOW;
                        end
                        acc_next   = '0;
                        cnt_next   = '0;
                        phase_next = B_MUL;
                    end
                end
            end
            B_MUL:
            begin
                // both weights walk msb first
                acc_next = (acc_reg << 1)
                         + (wb_reg[WT_W-1] ? NUM_W'(base_reg) : '0)
                         + (wm_reg[WT_W-1] ? NUM_W'(mag_reg) : '0);
                wb_next  = wb_reg << 1;
                wm_next  = wm_reg << 1;
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(WT_W - 1))
                begin
                    phase_next = B_LOAD;
                end
            end
            B_LOAD:
            begin
                // weights sum to 100, so the quotient fits the magnitude width
                rem_next   = REM_W'(num >> MAG_W);
                quo_next   = num[MAG_W-1:0];
                cnt_next   = '0;
                phase_next = B_DIV;
            end
            B_DIV:
            begin
                rem_next = q_bit ? REM_W'(trial - (REM_W+1)'(amd_pkg::BASE_DIVISOR))
                                 : REM_W'(trial);
                quo_next = {quo_reg[MAG_W-2:0], q_bit};
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(MAG_W - 1))
                begin
                    base_next  = {quo_reg[MAG_W-2:0], q_bit};
                    done_next  = 1'b1;
                    phase_next = B_IDLE;
                end
            end
            default:
            begin
                phase_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= B_IDLE;
            cnt_reg    <= '0;
            done_reg   <= 1'b0;
            valid_reg  <= 1'b0;
            still_reg  <= '0;
            base_reg   <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            cnt_reg    <= cnt_next;
            done_reg   <= done_next;
            valid_reg  <= valid_next;
            still_reg  <= still_next;
            base_reg   <= base_next;
        end
    end

    always_ff @(posedge clk)
    begin
        moving_reg <= moving_next;
        mag_reg    <= mag_next;
        wb_reg     <= wb_next;
        wm_reg     <= wm_next;
        acc_reg    <= acc_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
    end

    assign done                    = done_reg;
    assign result.moving           = moving_reg;
    assign result.window_magnitude = mag_reg;
    assign result.new_baseline     = base_reg;

endmodule

// ===== hw/rtl/accel_motion_detector.sv =====
// top level of the accelerometer motion detector: handshakes, config, sequencing
// depends on amd_pkg, amd_axis_lane, amd_sqrt, amd_baseline
//
//  channel  | signals                               | direction | item
//  ---------+---------------------------------------+-----------+--------------------------
//  in       | in_valid, in_ready, in_data           | in        | one x/y/z accel sample
//  out      | out_valid, out_ready, out_data        | out       | one result per window
//  cfg      | cfg_we, cfg_index, cfg_wdata          | in        | register write, no wait
//
// an item that does not close a window is only added into the lane sums
// the closing item runs three lanes in parallel: serial averaging and squaring,
//   then summing of the three squares, serial square root with rounding and
//   serial baseline update, in that order
// input waits until the result enters the output register, which needs it empty or being read
// reset clears the window, the baseline and the registers to their defaults
module accel_motion_detector #(
    parameter int WINDOW_SAMPLES = amd_pkg::WINDOW_SAMPLES_DEF,
    parameter int FRACTION_BITS  = amd_pkg::FRACTION_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  amd_pkg::in_item_t              in_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output amd_pkg::out_item_t             out_data,
    input  logic                           cfg_we,
    input  logic [amd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [amd_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    localparam int AVG_W    = amd_pkg::SAMPLE_W + FRACTION_BITS;
    localparam int SQ_W     = 2 * AVG_W;
    localparam int SQ_SUM_W = SQ_W + 2;
    localparam int PHASE_W  = (WINDOW_SAMPLES > 1) ? $clog2(WINDOW_SAMPLES) : 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LANE = 3'd1;
    localparam logic [2:0] S_SUM  = 3'd2;
    localparam logic [2:0] S_SQRT = 3'd3;
    localparam logic [2:0] S_BASE = 3'd4;
    localparam logic [2:0] S_HOLD = 3'd5;

    // control state
    logic [2:0]                  state_reg, state_next;
    logic [PHASE_W-1:0]          phase_reg, phase_next;
    logic                        out_valid_reg, out_valid_next;
    logic [amd_pkg::MAG_W-1:0]   threshold_reg, threshold_next;
    logic [amd_pkg::LIMIT_W-1:0] limit_reg, limit_next;

    // payload
    logic [SQ_SUM_W-1:0]         sq_acc_reg, sq_acc_next;
    amd_pkg::out_item_t          out_data_reg, out_data_next;

    amd_pkg::lane_ctl_t          lane_ctl;
    logic [2:0]                  lane_busy;
    logic [SQ_W-1:0]             sq_x, sq_y, sq_z;
    logic                        sqrt_start;
    logic [SQ_SUM_W-1:0]         radicand;
    logic                        sqrt_done;
    logic [amd_pkg::MAG_W-1:0]   magnitude;
    logic                        base_start;
    logic                        base_done;
    amd_pkg::out_item_t          base_result;
    logic                        out_load;
    logic                        in_accept;

    // inputs are only taken between windows' computations
    assign in_ready       = (state_reg == S_IDLE);
    assign in_accept      = in_valid && in_ready;
    assign lane_ctl.add   = in_accept;
    assign lane_ctl.close = in_accept && (phase_reg == PHASE_W'(WINDOW_SAMPLES - 1));

    amd_axis_lane #(
        .WINDOW_SAMPLES (WINDOW_SAMPLES),
        .FRACTION_BITS  (FRACTION_BITS)
    ) u_lane_x (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (lane_ctl),
        .accel  (in_data.accel_x),
        .busy   (lane_busy[0]),
        .square (sq_x)
    );

    amd_axis_lane #(
        .WINDOW_SAMPLES (WINDOW_SAMPLES),
        .FRACTION_BITS  (FRACTION_BITS)
    ) u_lane_y (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (lane_ctl),
        .accel  (in_data.accel_y),
        .busy   (lane_busy[1]),
        .square (sq_y)
    );

    amd_axis_lane #(
        .WINDOW_SAMPLES (WINDOW_SAMPLES),
        .FRACTION_BITS  (FRACTION_BITS)
    ) u_lane_z (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (lane_ctl),
        .accel  (in_data.accel_z),
        .busy   (lane_busy[2]),
        .square (sq_z)
    );

    // last of the three squares is added on the way into the root unit
    assign sqrt_start = (state_reg == S_SUM);
    assign radicand   = sq_acc_reg + SQ_SUM_W'(sq_z);

    amd_sqrt #(
        .RAD_W (SQ_SUM_W)
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (sqrt_start),
        .radicand  (radicand),
        .done      (sqrt_done),
        .magnitude (magnitude)
    );

    assign base_start = (state_reg == S_SQRT) && sqrt_done;

    amd_baseline u_baseline (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (base_start),
        .magnitude        (magnitude),
        .motion_threshold (threshold_reg),
        .still_limit      (limit_reg),
        .done             (base_done),
        .result           (base_result)
    );

    // result moves to the output register once that register is empty or being read
    assign out_load = (state_reg == S_HOLD) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        sq_acc_next    = sq_acc_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg;
        threshold_next = threshold_reg;
        limit_next     = limit_reg;

        if (cfg_we)
        begin
            case (cfg_index)
                amd_pkg::CFG_MOTION_THRESHOLD: threshold_next = cfg_wdata[amd_pkg::MAG_W-1:0];
                amd_pkg::CFG_STILL_LIMIT:      limit_next = cfg_wdata[amd_pkg::LIMIT_W-1:0];
                default:                       ;
            endcase
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (lane_ctl.close)
                begin
                    phase_next = '0;
                    state_next = S_LANE;
                end
                else if (in_accept)
                begin
                    phase_next = phase_reg + PHASE_W'(1);
                end
            end
            S_LANE:
            begin
                if (lane_busy == 3'b000)
                begin
                    sq_acc_next = SQ_SUM_W'(sq_x) + SQ_SUM_W'(sq_y);
                    state_next  = S_SUM;
                end
            end
            S_SUM:
            begin
                state_next = S_SQRT;
            end
            S_SQRT:
            begin
                if (sqrt_done)
                begin
                    state_next = S_BASE;
                end
            end
            S_BASE:
            begin
                if (base_done)
                begin
                    state_next = S_HOLD;
                end
            end
            S_HOLD:
            begin
                if (out_load)
                begin
                    out_data_next  = base_result;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= '0;
            out_valid_reg <= 1'b0;
            threshold_reg <= amd_pkg::THRESHOLD_RESET;
            limit_reg     <= amd_pkg::STILL_LIMIT_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
            threshold_reg <= threshold_next;
            limit_reg     <= limit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sq_acc_reg   <= sq_acc_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef SYNTHESIS
    // lanes must be idle whenever a new sample is summed in
    a_accept_lanes_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |-> (lane_busy == 3'b000))
        else $error("sample taken while axis lanes busy");

    // closing a window starts all three lanes together
    a_close_starts_lanes: assert property (@(posedge clk) disable iff (!rst_n)
        lane_ctl.close |=> (state_reg == S_LANE) && (lane_busy == 3'b111))
        else $error("window close did not start the lanes");

    a_sqrt_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        sqrt_done |-> (state_reg == S_SQRT))
        else $error("square root finished outside its step");

    a_base_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        base_done |-> (state_reg == S_BASE))
        else $error("baseline update finished outside its step");

    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg <= PHASE_W'(WINDOW_SAMPLES - 1))
        else $error("sample phase past window length");
`endif

endmodule
